// ===== hdl/adbkh_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, constants and code decoding for the ADB keyboard to HID report block.
package adbkh_pkg;

	localparam int CODE_W       = 7;
	localparam int USAGE_W      = 8;
	localparam int WORD_W       = 16;
	localparam int MAP_DEPTH    = 128;
	localparam int MAP_AW       = $clog2(MAP_DEPTH);
	localparam int KEY_SLOTS    = 6;
	localparam int REPORT_SLOTS = 6;

	localparam logic OP_KEYS      = 1'b0;
	localparam logic OP_MAP_WRITE = 1'b1;

	localparam logic [CODE_W-1:0] CODE_NONE   = 7'h7F;
	localparam logic [CODE_W-1:0] CODE_CAPS   = 7'h39;
	localparam logic [CODE_W-1:0] CODE_LCTRL  = 7'h36;
	localparam logic [CODE_W-1:0] CODE_LGUI   = 7'h37;
	localparam logic [CODE_W-1:0] CODE_LSHIFT = 7'h38;
	localparam logic [CODE_W-1:0] CODE_LALT   = 7'h3A;
	localparam logic [CODE_W-1:0] CODE_RSHIFT = 7'h7B;
	localparam logic [CODE_W-1:0] CODE_RALT   = 7'h7C;
	localparam logic [CODE_W-1:0] CODE_RCTRL  = 7'h7D;

	localparam logic [7:0] MOD_NONE   = 8'h00;
	localparam logic [7:0] MOD_LCTRL  = 8'h01;
	localparam logic [7:0] MOD_LSHIFT = 8'h02;
	localparam logic [7:0] MOD_LALT   = 8'h04;
	localparam logic [7:0] MOD_LGUI   = 8'h08;
	localparam logic [7:0] MOD_RCTRL  = 8'h10;
	localparam logic [7:0] MOD_RSHIFT = 8'h20;
	localparam logic [7:0] MOD_RALT   = 8'h40;

	typedef struct packed {
		logic              clear;
		logic [CODE_W-1:0] code_a;
		logic              up_a;
		logic [CODE_W-1:0] code_b;
		logic              up_b;
	} evt_t;

	function automatic logic [7:0] modifier_for(input logic [CODE_W-1:0] code);
		logic [7:0] mbit;
		case (code)
			CODE_LCTRL:  mbit = MOD_LCTRL;
			CODE_LSHIFT: mbit = MOD_LSHIFT;
			CODE_LALT:   mbit = MOD_LALT;
			CODE_LGUI:   mbit = MOD_LGUI;
			CODE_RCTRL:  mbit = MOD_RCTRL;
			CODE_RSHIFT: mbit = MOD_RSHIFT;
			CODE_RALT:   mbit = MOD_RALT;
			default:     mbit = MOD_NONE;
		endcase
		return mbit;
	endfunction

endpackage

// ===== hdl/adbkh_ram.sv =====
`timescale 1ns / 1ps
// Generic single-write, single-read synchronous RAM with a registered read.
module adbkh_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 128
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

// ===== hdl/adbkh_map.sv =====
`timescale 1ns / 1ps
// ADB-to-HID usage map: two RAM copies for two lookups a cycle, with per-entry valid bits.
module adbkh_map (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                wr_en,
	input  logic [adbkh_pkg::MAP_AW-1:0]        wr_addr,
	input  logic [adbkh_pkg::USAGE_W-1:0]       wr_data,
	input  logic                                rd_en,
	input  logic [adbkh_pkg::MAP_AW-1:0]        addr_a,
	input  logic [adbkh_pkg::MAP_AW-1:0]        addr_b,
	output logic [adbkh_pkg::USAGE_W-1:0]       usage_a,
	output logic [adbkh_pkg::USAGE_W-1:0]       usage_b
);

	logic [adbkh_pkg::MAP_DEPTH-1:0] vld_q;
	logic                            vld_a_q;
	logic                            vld_b_q;
	logic [adbkh_pkg::USAGE_W-1:0]   data_a;
	logic [adbkh_pkg::USAGE_W-1:0]   data_b;

	adbkh_ram #(
		.WIDTH(adbkh_pkg::USAGE_W),
		.DEPTH(adbkh_pkg::MAP_DEPTH)
	) u_ram_a (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (addr_a),
		.rd_data (data_a)
	);

	adbkh_ram #(
		.WIDTH(adbkh_pkg::USAGE_W),
		.DEPTH(adbkh_pkg::MAP_DEPTH)
	) u_ram_b (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (addr_b),
		.rd_data (data_b)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q   <= '0;
			vld_a_q <= 1'b0;
			vld_b_q <= 1'b0;
		end else begin
			if (wr_en) begin
				vld_q[wr_addr] <= 1'b1;
			end
			if (rd_en) begin
				vld_a_q <= vld_q[addr_a];
				vld_b_q <= vld_q[addr_b];
			end
		end
	end

	// An entry never written reads as unmapped.
	assign usage_a = vld_a_q ? data_a : '0;
	assign usage_b = vld_b_q ? data_b : '0;

endmodule

// ===== hdl/adbkh_slots.sv =====
`timescale 1ns / 1ps
// Key slot and modifier state with the two-event update applied per keyboard word.
module adbkh_slots #(
	parameter int KEY_SLOTS = adbkh_pkg::KEY_SLOTS
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          commit,
	input  adbkh_pkg::evt_t               evt,
	input  logic [adbkh_pkg::USAGE_W-1:0] usage_a,
	input  logic [adbkh_pkg::USAGE_W-1:0] usage_b,
	output logic [7:0]                    mods_n,
	output logic [adbkh_pkg::USAGE_W-1:0] slots_n [KEY_SLOTS]
);

	logic [7:0]                    mods_q;
	logic [adbkh_pkg::USAGE_W-1:0] slots_q [KEY_SLOTS];

	always_comb begin
		logic [adbkh_pkg::CODE_W-1:0]  code;
		logic                          up;
		logic [adbkh_pkg::USAGE_W-1:0] usage;
		logic [7:0]                    mbit;
		logic                          hit;
		logic                          placed;
		mods_n  = mods_q;
		slots_n = slots_q;
		code    = '0;
		up      = 1'b0;
		usage   = '0;
		mbit    = '0;
		hit     = 1'b0;
		placed  = 1'b0;
		if (evt.clear) begin
			mods_n = '0;
			for (int i = 0; i < KEY_SLOTS; i++) begin
				slots_n[i] = '0;
			end
		end else begin
			for (int e = 0; e < 2; e++) begin
				code   = (e == 0) ? evt.code_a : evt.code_b;
				up     = (e == 0) ? evt.up_a : evt.up_b;
				usage  = (e == 0) ? usage_a : usage_b;
				mbit   = adbkh_pkg::modifier_for(code);
				hit    = 1'b0;
				placed = 1'b0;
				if (code != adbkh_pkg::CODE_NONE && code != adbkh_pkg::CODE_CAPS) begin
					if (mbit != adbkh_pkg::MOD_NONE) begin
						mods_n = up ? (mods_n & ~mbit) : (mods_n | mbit);
					end else if (usage != '0) begin
						if (up) begin
							for (int i = 0; i < KEY_SLOTS; i++) begin
								if (slots_n[i] == usage) begin
									slots_n[i] = '0;
								end
							end
						end else begin
							for (int i = 0; i < KEY_SLOTS; i++) begin
								hit = hit | (slots_n[i] == usage);
							end
							if (!hit) begin
								for (int i = 0; i < KEY_SLOTS; i++) begin
									if (!placed && slots_n[i] == '0) begin
										slots_n[i] = usage;
										placed     = 1'b1;
									end
								end
							end
						end
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mods_q <= '0;
			for (int i = 0; i < KEY_SLOTS; i++) begin
				slots_q[i] <= '0;
			end
		end else if (commit) begin
			mods_q  <= mods_n;
			slots_q <= slots_n;
		end
	end

endmodule

// ===== hdl/adb_keyboard_to_hid_report_top.sv =====
`timescale 1ns / 1ps
// Top level of the ADB keyboard register 0 to HID boot keyboard report converter.
// Each transaction either writes one entry of the ADB-to-HID usage map (operation 1,
// no report) or applies the two key events of an ADB register 0 word and returns one
// report (operation 0). The block takes one transaction per clock cycle while its
// output is not stalled: the map is read and the word's events are registered at the
// edge that accepts a word, and the slot and modifier update is computed from those
// registers and lands in the output register when it commits, which a stalled output
// holds back. The key slot update depends on the previous word's result. The map is
// held in two RAM copies so that both codes of a word are looked up at once; it reads
// as all unmapped after reset, with no clearing pass.
module adb_keyboard_to_hid_report_top #(
	parameter int KEY_SLOTS = adbkh_pkg::KEY_SLOTS
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic                                operation,
	input  logic [adbkh_pkg::WORD_W-1:0]        register_word,
	input  logic [adbkh_pkg::CODE_W-1:0]        map_index,
	input  logic [adbkh_pkg::USAGE_W-1:0]       map_value,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic [7:0]                          modifier_bits,
	output logic [adbkh_pkg::USAGE_W-1:0]       slot_zero,
	output logic [adbkh_pkg::USAGE_W-1:0]       slot_one,
	output logic [adbkh_pkg::USAGE_W-1:0]       slot_two,
	output logic [adbkh_pkg::USAGE_W-1:0]       slot_three,
	output logic [adbkh_pkg::USAGE_W-1:0]       slot_four,
	output logic [adbkh_pkg::USAGE_W-1:0]       slot_five
);

	logic                          accept;
	logic                          acc_keys;
	logic                          acc_map;
	logic                          advance;
	logic                          commit;
	logic                          s1_valid_q;
	adbkh_pkg::evt_t               evt_s1;
	adbkh_pkg::evt_t               evt_in;
	logic [adbkh_pkg::USAGE_W-1:0] usage_a;
	logic [adbkh_pkg::USAGE_W-1:0] usage_b;
	logic [7:0]                    mods_n;
	logic [adbkh_pkg::USAGE_W-1:0] slots_n [KEY_SLOTS];
	logic [adbkh_pkg::USAGE_W-1:0] rpt_n [adbkh_pkg::REPORT_SLOTS];
	logic                          out_valid_q;
	logic [7:0]                    mods_out_q;
	logic [adbkh_pkg::USAGE_W-1:0] rpt_q [adbkh_pkg::REPORT_SLOTS];

	assign advance  = !out_valid_q || !out_stall;
	assign commit   = s1_valid_q && advance;
	assign in_stall = s1_valid_q && !advance;
	assign accept   = in_valid && !in_stall;
	assign acc_keys = accept && operation == adbkh_pkg::OP_KEYS;
	assign acc_map  = accept && operation == adbkh_pkg::OP_MAP_WRITE;

	assign evt_in.code_a = register_word[14:8];
	assign evt_in.up_a   = register_word[15];
	assign evt_in.code_b = register_word[6:0];
	assign evt_in.up_b   = register_word[7];
	assign evt_in.clear  = (register_word == '0)
		|| (register_word[14:8] == adbkh_pkg::CODE_NONE
		&& register_word[6:0] == adbkh_pkg::CODE_NONE);

	adbkh_map u_map (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (acc_map),
		.wr_addr (map_index),
		.wr_data (map_value),
		.rd_en   (acc_keys),
		.addr_a  (register_word[14:8]),
		.addr_b  (register_word[6:0]),
		.usage_a (usage_a),
		.usage_b (usage_b)
	);

	adbkh_slots #(
		.KEY_SLOTS(KEY_SLOTS)
	) u_slots (
		.clk     (clk),
		.arst_n  (arst_n),
		.commit  (commit),
		.evt     (evt_s1),
		.usage_a (usage_a),
		.usage_b (usage_b),
		.mods_n  (mods_n),
		.slots_n (slots_n)
	);

	for (genvar j = 0; j < adbkh_pkg::REPORT_SLOTS; j++) begin : g_rpt
		if (j < KEY_SLOTS) begin : g_used
			assign rpt_n[j] = slots_n[j];
		end else begin : g_empty
			assign rpt_n[j] = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (acc_keys) begin
				s1_valid_q <= 1'b1;
			end else if (commit) begin
				s1_valid_q <= 1'b0;
			end
			if (commit) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc_keys) begin
			evt_s1 <= evt_in;
		end
		if (commit) begin
			mods_out_q <= mods_n;
			rpt_q      <= rpt_n;
		end
	end

	assign out_valid     = out_valid_q;
	assign modifier_bits = mods_out_q;
	assign slot_zero     = rpt_q[0];
	assign slot_one      = rpt_q[1];
	assign slot_two      = rpt_q[2];
	assign slot_three    = rpt_q[3];
	assign slot_four     = rpt_q[4];
	assign slot_five     = rpt_q[5];

endmodule
